>>> sv/periodic_event_timer_bank_defines.svh
// Assertion macros for the periodic event timer bank.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef PERIODIC_EVENT_TIMER_BANK_DEFINES_SVH
`define PERIODIC_EVENT_TIMER_BANK_DEFINES_SVH

// Property checked only while out of reset
`define PETB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define PETB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/petb_pkg.sv
// Shared types and constants for the periodic event timer bank.
// No dependencies; used by every module of the block.
`default_nettype none

package petb_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths of the stream words
  localparam int SLOT_ID_W   = 4;
  localparam int PERIOD_W    = 16;
  localparam int DELAY_W     = 16;
  localparam int NOW_W       = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_REMOVED = 3'd1,
    ST_FIRED   = 3'd2,
    ST_TICK    = 3'd3,
    ST_CLEARED = 3'd4,
    ST_ERROR   = 3'd5
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;      // latch request fields, zero the walk counters
    logic    scan_inc;     // advance free-slot scan
    logic    add_commit;   // claim scanned slot
    logic    tick_init;    // compute elapsed time, record time
    logic    idx_inc;      // advance order list read index
    logic    slot_latch;   // take slot number from order list
    logic    sub;          // countdown minus elapsed
    logic    chk_step;     // fire check, reload or free, compact
    logic    rem_step;     // compact order list around removed slot
    logic    rem_commit;   // free removed slot, update count
    logic    tick_commit;  // update count after tick
    logic    clear_all;    // empty bank and stop
    logic    emit;         // load output register
    status_t emit_status;
    logic    emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a word
    logic full;       // all slots in use
    logic cur_free;   // scanned slot is free
    logic rem_ok;     // remove target is in range and in use
    logic cnt_zero;   // no active slots
    logic idx_last;   // entry just read is the last active one
    logic due;        // countdown at or below zero
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/petb_ctrl.sv
// Request sequencer for the periodic event timer bank.
// Depends on petb_pkg; drives petb_dp through command/status structs.
`default_nettype none

module petb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [1:0]         in_tuser,
  output logic               in_tready,
  input  petb_pkg::dp_stat_t stat,
  output petb_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_SCAN,
    S_REM_CHK,
    S_REM_START,
    S_REM_CMP,
    S_TICK_START,
    S_TICK_SLOT,
    S_TICK_SUB,
    S_TICK_CHK,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  petb_pkg::status_t fin_r, fin_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    cmd             = '0;
    cmd.emit_status = petb_pkg::ST_FIRED;
    state_nxt       = state_r;
    fin_nxt         = fin_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          unique case (petb_pkg::req_t'(in_tuser))
            petb_pkg::REQ_ADD:    state_nxt = S_ADD_CHK;
            petb_pkg::REQ_REMOVE: state_nxt = S_REM_CHK;
            petb_pkg::REQ_TICK:   state_nxt = S_TICK_START;
            petb_pkg::REQ_CLEAR: begin
              cmd.clear_all = 1'b1;
              fin_nxt       = petb_pkg::ST_CLEARED;
              state_nxt     = S_DONE;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        if (stat.full) begin
          fin_nxt   = petb_pkg::ST_ERROR;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADD_SCAN;
        end
      end
      S_ADD_SCAN: begin
        if (stat.cur_free) begin
          cmd.add_commit = 1'b1;
          fin_nxt        = petb_pkg::ST_ADDED;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_REM_CHK: begin
        if (stat.rem_ok) begin
          state_nxt = S_REM_START;
        end else begin
          fin_nxt   = petb_pkg::ST_ERROR;
          state_nxt = S_DONE;
        end
      end
      S_REM_START: begin
        cmd.idx_inc = 1'b1;
        state_nxt   = S_REM_CMP;
      end
      S_REM_CMP: begin
        cmd.rem_step = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          fin_nxt   = petb_pkg::ST_REMOVED;
          state_nxt = S_DONE;
        end
      end
      S_TICK_START: begin
        cmd.tick_init = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (stat.cnt_zero) begin
          fin_nxt   = petb_pkg::ST_TICK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TICK_SLOT;
        end
      end
      S_TICK_SLOT: begin
        cmd.slot_latch = 1'b1;
        state_nxt      = S_TICK_SUB;
      end
      S_TICK_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        // a firing slot waits here until the output register is free
        if (!stat.due || stat.out_free) begin
          cmd.chk_step    = 1'b1;
          cmd.idx_inc     = 1'b1;
          cmd.emit        = stat.due;
          cmd.emit_status = petb_pkg::ST_FIRED;
          cmd.emit_last   = 1'b0;
          if (stat.idx_last) begin
            fin_nxt   = petb_pkg::ST_TICK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TICK_SLOT;
          end
        end
      end
      S_DONE: begin
        cmd.rem_commit  = (fin_r == petb_pkg::ST_REMOVED);
        cmd.tick_commit = (fin_r == petb_pkg::ST_TICK);
        cmd.emit_status = fin_r;
        cmd.emit_last   = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and final status register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= petb_pkg::ST_ERROR;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/petb_dp.sv
// Datapath of the periodic event timer bank: slot stores, counters,
// countdown arithmetic and output register. Depends on petb_pkg.
`default_nettype none

module petb_dp #(
  parameter int SLOTS     = petb_pkg::SLOTS_DEF,
  parameter int TIME_BITS = petb_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [petb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  petb_pkg::dp_cmd_t                  cmd,
  output petb_pkg::dp_stat_t                 stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [petb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [2:0]                         out_tuser,
  output logic                               out_tlast
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SIW = petb_pkg::SLOT_ID_W;
  localparam int PW  = petb_pkg::PERIOD_W;
  localparam int DW  = petb_pkg::DELAY_W;
  localparam int NW  = petb_pkg::NOW_W;

  // Request fields
  logic [SIW-1:0]       sid_r;
  logic [PW-1:0]        period_r;
  logic [DW-1:0]        delay_r;
  logic [TIME_BITS-1:0] now_r;

  // Bank control state
  logic [SLOTS-1:0]     valid_r;
  logic [CW-1:0]        count_r;
  logic [TIME_BITS-1:0] prev_r;
  logic                 running_r;
  logic [TIME_BITS-1:0] elapsed_r;

  // Walk counters
  logic [CW-1:0]        rd_idx_r;
  logic [CW-1:0]        wr_idx_r;
  logic [SW-1:0]        scan_r;

  // Tick pipeline
  logic [SW-1:0]        s_r;
  logic [TIME_BITS-1:0] c_r;
  logic [PW-1:0]        pr_r;

  // Slot stores
  logic [TIME_BITS-1:0] cd_mem  [SLOTS];
  logic [PW-1:0]        per_mem [SLOTS];
  logic [SW-1:0]        ord_mem [SLOTS];
  logic [TIME_BITS-1:0] cd_q;
  logic [PW-1:0]        per_q;
  logic [SW-1:0]        ord_q;

  // Output register
  logic                 out_valid_r;
  petb_pkg::status_t    out_status_r;
  logic [SIW-1:0]       out_slot_r;
  logic                 out_last_r;

  logic [SW-1:0]        sid_idx;
  logic                 sid_in_range;
  logic                 due;
  logic                 per_zero;
  logic                 tick_keep;
  logic                 rem_keep;
  logic                 ord_we;
  logic [SW-1:0]        ord_wa;
  logic [SW-1:0]        ord_wd;
  logic                 cd_we;
  logic [SW-1:0]        cd_wa;
  logic [TIME_BITS-1:0] cd_wd;
  logic [SIW-1:0]       emit_slot;

  // Decode and status
  assign sid_idx      = SW'(sid_r);
  assign sid_in_range = (int'(sid_r) < SLOTS);
  assign due          = (c_r == '0) || c_r[TIME_BITS-1];
  assign per_zero     = (pr_r == '0);
  assign tick_keep    = !(due && per_zero);
  assign rem_keep     = (ord_q != sid_idx);

  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.full     = (count_r >= CW'(SLOTS));
  assign stat.cur_free = !valid_r[scan_r];
  assign stat.rem_ok   = sid_in_range && valid_r[sid_idx];
  assign stat.cnt_zero = (count_r == '0);
  assign stat.idx_last = (rd_idx_r == count_r);
  assign stat.due      = due;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sid_r    <= in_tdata[SIW-1:0];
      period_r <= in_tdata[SIW+PW-1:SIW];
      delay_r  <= in_tdata[SIW+PW+DW-1:SIW+PW];
      now_r    <= TIME_BITS'(in_tdata[SIW+PW+DW+NW-1:SIW+PW+DW]);
    end
  end

  // Store write selection
  always_comb begin
    ord_we = 1'b0;
    ord_wa = wr_idx_r[SW-1:0];
    ord_wd = s_r;
    cd_we  = 1'b0;
    cd_wa  = s_r;
    cd_wd  = due ? (c_r + TIME_BITS'(pr_r)) : c_r;
    priority if (cmd.add_commit) begin
      ord_we = 1'b1;
      ord_wa = count_r[SW-1:0];
      ord_wd = scan_r;
      cd_we  = 1'b1;
      cd_wa  = scan_r;
      cd_wd  = TIME_BITS'(delay_r);
    end else if (cmd.chk_step) begin
      ord_we = tick_keep;
      cd_we  = tick_keep;
    end else if (cmd.rem_step) begin
      ord_we = rem_keep;
      ord_wd = ord_q;
    end
  end

  // Slot stores, registered reads
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
    if (cmd.add_commit) begin
      per_mem[scan_r] <= period_r;
    end
    ord_q <= ord_mem[rd_idx_r[SW-1:0]];
    cd_q  <= cd_mem[ord_q];
    per_q <= per_mem[ord_q];
  end

  // Bank state and walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      prev_r    <= '0;
      running_r <= 1'b0;
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      scan_r    <= '0;
    end else begin
      if (cmd.capture) begin
        rd_idx_r <= '0;
        wr_idx_r <= '0;
        scan_r   <= '0;
      end
      if (cmd.scan_inc) begin
        scan_r <= scan_r + SW'(1);
      end
      if (cmd.idx_inc) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if ((cmd.chk_step && tick_keep) || (cmd.rem_step && rem_keep)) begin
        wr_idx_r <= wr_idx_r + CW'(1);
      end
      if (cmd.tick_init) begin
        prev_r    <= now_r;
        running_r <= 1'b1;
      end
      if (cmd.add_commit) begin
        valid_r[scan_r] <= 1'b1;
        count_r         <= count_r + CW'(1);
      end
      if (cmd.chk_step && !tick_keep) begin
        valid_r[s_r] <= 1'b0;
      end
      if (cmd.rem_commit) begin
        valid_r[sid_idx] <= 1'b0;
      end
      if (cmd.rem_commit || cmd.tick_commit) begin
        count_r <= wr_idx_r;
      end
      if (cmd.clear_all) begin
        valid_r   <= '0;
        count_r   <= '0;
        running_r <= 1'b0;
      end
    end
  end

  // Tick arithmetic
  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      elapsed_r <= running_r ? (now_r - prev_r) : '0;
    end
    if (cmd.slot_latch) begin
      s_r <= ord_q;
    end
    if (cmd.sub) begin
      c_r  <= cd_q - elapsed_r;
      pr_r <= per_q;
    end
  end

  // Slot reported with each result
  always_comb begin
    unique case (cmd.emit_status)
      petb_pkg::ST_ADDED:   emit_slot = SIW'(scan_r);
      petb_pkg::ST_REMOVED: emit_slot = sid_r;
      petb_pkg::ST_FIRED:   emit_slot = SIW'(s_r);
      default:              emit_slot = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_slot_r   <= emit_slot;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = petb_pkg::OUT_TDATA_W'(out_slot_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> sv/periodic_event_timer_bank.sv
// Periodic event timer bank: a fixed bank of periodic and one-shot timers.
//
// Input channel (in_*): one word per request; in_tuser is the request kind
// (add, remove, tick, clear). Output channel (out_*): result words, the
// last word of each request flagged by out_tlast. A tick gives one fired
// word per expiring slot in insertion order, then a tick-done word.
// One request is worked at a time; in_tready is high only between requests,
// so the next request is taken only after the final word is loaded.
// An add scans to the lowest free slot; a remove or a tick walks the active
// slots in order. For each active slot a tick steps through order list
// read, countdown/period read, subtract, then fire check and write-back,
// paced by the registered reads of the slot stores.
// Results sit in an output register; when the receiver stalls, a firing
// slot holds the walk until the word before it is taken.
// Reset (rst_n low, synchronous) empties the bank and stops it; the first
// tick afterwards counts no time as elapsed and records the time.
// Depends on petb_pkg, petb_ctrl and petb_dp.
`default_nettype none

module periodic_event_timer_bank #(
  parameter int SLOTS     = petb_pkg::SLOTS_DEF,
  parameter int TIME_BITS = petb_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot_id[3:0], period[19:4], first_delay[35:20], now_time[67:36], zero pad
  input  logic [petb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot_out[3:0], zero pad
  output logic [petb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [2:0]                       out_tuser,
  output logic                             out_tlast
);

  petb_pkg::dp_cmd_t  cmd;
  petb_pkg::dp_stat_t stat;

  petb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  petb_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> sv/petb_checker.sv
// Port-level checks for the periodic event timer bank, bound to the top.
// Depends on petb_pkg and periodic_event_timer_bank_defines.svh.
`default_nettype none
`include "periodic_event_timer_bank_defines.svh"

module petb_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [petb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [2:0]                       out_tuser,
  input wire logic                             out_tlast
);

  // a stalled result word holds
  `PETB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result word changed under stall")

  // one request at a time
  `PETB_ASSERT(a_one_req, in_tvalid && in_tready |=> !in_tready, "second request taken while busy")

  // fired words never close a request, all other kinds always do
  `PETB_ASSERT(a_fired_last, out_tvalid |-> ((out_tuser == petb_pkg::ST_FIRED) != out_tlast), "last flag does not match word kind")

  // tick done, cleared and error carry no slot
  `PETB_ASSERT(a_no_slot, out_tvalid && (out_tuser == petb_pkg::ST_TICK || out_tuser == petb_pkg::ST_CLEARED || out_tuser == petb_pkg::ST_ERROR) |-> out_tdata == '0, "slot set on a slotless word")

  // reset drops the output
  `PETB_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind periodic_event_timer_bank petb_checker u_petb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
